// ===== hw/rtl/aash_pkg.sv =====
// Shared types and constants for the anti-aliased scanline shear block.
`timescale 1ns / 1ps
package aash_pkg;

  localparam int FracBits  = 8;
  localparam int One       = 1 << FracBits;
  localparam int MaxWidth  = 4096;
  localparam int XW        = $clog2(MaxWidth);
  localparam int DstWidthW = 13;
  localparam int PosInW    = 21;
  localparam int FloorW    = PosInW - FracBits;
  localparam int PosW      = 14;
  localparam int PosMax    = (1 << (PosW - 1)) - 1;
  localparam int WeightW   = FracBits + 1;
  localparam int ByteW     = 8;
  localparam int NumChan   = 3;
  localparam int PixW      = 32;
  localparam int ProdW     = ByteW + WeightW;
  localparam int AccW      = ProdW + 2;
  localparam int NumTaps   = 3;
  localparam int MidTap    = 1;
  localparam int CfgW      = 32;
  localparam int CfgIdxW   = 1;

  localparam logic [PixW-1:0]      BorderReset   = 32'hFF00_0000;
  localparam logic [DstWidthW-1:0] DstWidthReset = DstWidthW'(MaxWidth);

  typedef enum logic [CfgIdxW-1:0] {
    RegBorderColor = 1'b0,
    RegDstWidth    = 1'b1
  } reg_idx_e;

  typedef logic [PixW-1:0]                     pix_t;
  typedef logic [WeightW-1:0]                  weight_t;
  typedef logic signed [PosW-1:0]              pos_t;
  typedef logic [NumChan-1:0][ProdW-1:0]       chan_prod_t;

  typedef struct packed {
    weight_t w_old;
    weight_t w_mid;
    weight_t w_new;
    pos_t    start;
  } line_param_t;

  typedef struct packed {
    logic shift;
    logic prod_load;
  } cell_ctrl_t;

endpackage

// ===== hw/rtl/aash_if.sv =====
// Stream interfaces for source pixels and sheared result beats.
`timescale 1ns / 1ps
interface aash_in_if;
  import aash_pkg::*;
  logic                     valid;
  logic                     ready;
  logic                     line_start;
  logic signed [PosInW-1:0] top_pos;
  logic signed [PosInW-1:0] bottom_pos;
  logic [PixW-1:0]          pixel;
  logic                     pixel_inside;
  logic                     line_end;

  modport source (output valid, line_start, top_pos, bottom_pos, pixel, pixel_inside,
                  line_end, input ready);
  modport sink (input valid, line_start, top_pos, bottom_pos, pixel, pixel_inside,
                line_end, output ready);
endinterface

interface aash_out_if;
  import aash_pkg::*;
  logic            valid;
  logic            ready;
  logic            write_enable;
  logic [XW-1:0]   dst_x;
  logic [PixW-1:0] color;
  logic            end_of_line;

  modport source (output valid, write_enable, dst_x, color, end_of_line, input ready);
  modport sink (input valid, write_enable, dst_x, color, end_of_line, output ready);
endinterface

// ===== hw/rtl/aash_weight_calc.sv =====
// Line-start filter weights and first destination x from the top and bottom edge positions.
`timescale 1ns / 1ps
module aash_weight_calc (
  input  logic signed [aash_pkg::PosInW-1:0] top_pos_i,
  input  logic signed [aash_pkg::PosInW-1:0] bottom_pos_i,
  output aash_pkg::line_param_t              param_o
);
  import aash_pkg::*;

  logic signed [FloorW-1:0]  ft, fb, fmin;
  logic [FracBits-1:0]       tf, bf, near_frac;
  logic                      same_px, b_lt_t;
  logic signed [PosInW-1:0]  near, far;
  logic signed [PosInW:0]    far_x, near_al, diff;
  logic [PosInW-1:0]         half;
  logic [FracBits+1:0]       sum_e;
  logic [FracBits:0]         nf;
  weight_t                   w2_eq, w2_ne, w0_ne, w0, w2;
  logic signed [WeightW+1:0] mid_s;

  always_comb begin
    ft      = top_pos_i[PosInW-1:FracBits];
    fb      = bottom_pos_i[PosInW-1:FracBits];
    tf      = top_pos_i[FracBits-1:0];
    bf      = bottom_pos_i[FracBits-1:0];
    same_px = (ft == fb);
    b_lt_t  = (fb < ft);

    // both edges in one pixel: new weight is the mean uncovered fraction
    sum_e = (FracBits+2)'(2 * One) - {2'b00, tf} - {2'b00, bf};
    w2_eq = sum_e[FracBits+1:1];

    near      = b_lt_t ? bottom_pos_i : top_pos_i;
    far       = b_lt_t ? top_pos_i : bottom_pos_i;
    near_frac = b_lt_t ? bf : tf;
    nf        = (FracBits+1)'(One) - {1'b0, near_frac};
    w2_ne     = WeightW'(nf[FracBits:1]);

    // far edge minus the pixel boundary after the near edge, never negative here
    far_x   = {far[PosInW-1], far};
    near_al = {near[PosInW-1], near[PosInW-1:FracBits], {FracBits{1'b0}}};
    diff    = far_x - near_al - (PosInW+1)'(One);
    half    = diff[PosInW:1];
    w0_ne   = (half > PosInW'(One)) ? WeightW'(One) : half[WeightW-1:0];

    w0    = same_px ? '0 : w0_ne;
    w2    = same_px ? w2_eq : w2_ne;
    mid_s = (WeightW+2)'(One) - {2'b00, w0} - {2'b00, w2};

    fmin          = (ft < fb) ? ft : fb;
    param_o.w_old = w0;
    param_o.w_new = w2;
    param_o.w_mid = mid_s[WeightW+1] ? '0 : mid_s[WeightW-1:0];
    param_o.start = {{(PosW-FloorW){fmin[FloorW-1]}}, fmin};
  end

endmodule

// ===== hw/rtl/aash_tap_cell.sv =====
// One window tap: holds a pixel, hands it to the older neighbor, weights its color bytes.
`timescale 1ns / 1ps
module aash_tap_cell (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  aash_pkg::cell_ctrl_t  ctrl_i,
  input  aash_pkg::pix_t        pix_i,
  input  aash_pkg::weight_t     weight_i,
  output aash_pkg::pix_t        pix_o,
  output aash_pkg::chan_prod_t  prod_o
);
  import aash_pkg::*;

  pix_t       pix_q;
  chan_prod_t prod_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pix_q <= BorderReset;
    end else if (ctrl_i.shift) begin
      pix_q <= pix_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.prod_load) begin
      for (int ch = 0; ch < NumChan; ch++) begin
        prod_q[ch] <= ProdW'(pix_q[ch*ByteW +: ByteW]) * ProdW'(weight_i);
      end
    end
  end

  assign pix_o  = pix_q;
  assign prod_o = prod_q;

endmodule

// ===== hw/rtl/antialiased_scanline_shear_top.sv =====
// Top level: tap-cell window, weight and position state, mixer and output stage.
// Each beat is registered in stages A (window), B (products) and C (output register) in turn.
// Throughput: one beat per cycle unless all three stages are full while the output stalls;
//   each of the three tap cells does its three byte products per load into stage B.
// Reset: window holds 0xFF000000, weights are (0, one, 0), destination x is 0,
//   border color 0xFF000000 and destination width 4096; the pipeline is empty.
`timescale 1ns / 1ps
module antialiased_scanline_shear_top (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [aash_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  logic [aash_pkg::CfgW-1:0]    cfg_data_i,
  aash_in_if.sink                      pix_i,
  aash_out_if.source                   res_o
);
  import aash_pkg::*;

  // configuration
  pix_t                 border_q;
  logic [DstWidthW-1:0] dst_width_q, limit;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      border_q    <= BorderReset;
      dst_width_q <= DstWidthReset;
    end else if (cfg_we_i) begin
      case (reg_idx_e'(cfg_idx_i))
        RegBorderColor: border_q    <= cfg_data_i[PixW-1:0];
        RegDstWidth:    dst_width_q <= cfg_data_i[DstWidthW-1:0];
        default: ;
      endcase
    end
  end

  assign limit = (dst_width_q > DstWidthW'(MaxWidth)) ? DstWidthW'(MaxWidth) : dst_width_q;

  // pipeline flow
  logic a_valid_q, b_valid_q, c_valid_q;
  logic a_en, b_en, c_en, accept;

  assign c_en        = !c_valid_q || res_o.ready;
  assign b_en        = !b_valid_q || c_en;
  assign a_en        = !a_valid_q || b_en;
  assign pix_i.ready = a_en;
  assign accept      = pix_i.valid && a_en;

  // line parameters and destination position
  line_param_t lp;
  weight_t     w_q [NumTaps];
  pos_t        dest_pos_q, pos_cur;
  logic        we_cur;

  aash_weight_calc u_weight (
    .top_pos_i    (pix_i.top_pos),
    .bottom_pos_i (pix_i.bottom_pos),
    .param_o      (lp)
  );

  always_comb begin
    pos_cur = pix_i.line_start ? lp.start : dest_pos_q;
    we_cur  = !pos_cur[PosW-1] && (pos_cur[PosW-2:0] < (PosW-1)'(limit));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dest_pos_q <= '0;
      for (int k = 0; k < NumTaps; k++) begin
        w_q[k] <= (k == MidTap) ? WeightW'(One) : '0;
      end
    end else if (accept) begin
      // saturate so the position never wraps into the visible range
      dest_pos_q <= (pos_cur != PosW'(PosMax)) ? pos_cur + PosW'(1) : pos_cur;
      if (pix_i.line_start) begin
        w_q[0] <= lp.w_old;
        w_q[1] <= lp.w_mid;
        w_q[2] <= lp.w_new;
      end
    end
  end

  // tap cells: index 0 is the oldest pixel
  cell_ctrl_t ctrl;
  pix_t       win    [NumTaps];
  pix_t       win_in [NumTaps];
  chan_prod_t prod   [NumTaps];

  assign ctrl.shift     = accept;
  assign ctrl.prod_load = a_valid_q && b_en;

  for (genvar k = 0; k < NumTaps; k++) begin : g_tap
    if (k == NumTaps - 1) begin : g_newest
      assign win_in[k] = pix_i.pixel_inside ? pix_i.pixel : border_q;
    end else begin : g_older
      // a new line refills the window with border before the shift
      assign win_in[k] = pix_i.line_start ? border_q : win[k+1];
    end

    aash_tap_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .pix_i    (win_in[k]),
      .weight_i (w_q[k]),
      .pix_o    (win[k]),
      .prod_o   (prod[k])
    );
  end

  // stage A: window state updated, per-beat side data
  logic          a_we_q, a_eol_q;
  logic [XW-1:0] a_x_q;

  // stage B: products held in the cells
  logic            b_we_q, b_eol_q;
  logic [XW-1:0]   b_x_q;
  logic [ByteW-1:0] b_alpha_q;

  // stage C: output register
  logic            c_we_q, c_eol_q;
  logic [XW-1:0]   c_x_q;
  pix_t            c_color_q, color_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
      b_valid_q <= 1'b0;
      c_valid_q <= 1'b0;
    end else begin
      if (a_en) a_valid_q <= pix_i.valid;
      if (b_en) b_valid_q <= a_valid_q;
      if (c_en) c_valid_q <= b_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      a_we_q  <= we_cur;
      a_x_q   <= we_cur ? pos_cur[XW-1:0] : '0;
      a_eol_q <= pix_i.line_end;
    end
    if (ctrl.prod_load) begin
      b_we_q    <= a_we_q;
      b_x_q     <= a_x_q;
      b_eol_q   <= a_eol_q;
      b_alpha_q <= win[0][PixW-1 -: ByteW];
    end
    if (c_en && b_valid_q) begin
      c_we_q    <= b_we_q;
      c_x_q     <= b_x_q;
      c_eol_q   <= b_eol_q;
      c_color_q <= color_d;
    end
  end

  // mixer: sum the three taps per channel, drop the fraction, clip to a byte
  logic [NumChan-1:0][AccW-1:0]          acc;
  logic [NumChan-1:0][AccW-FracBits-1:0] acc_int;

  always_comb begin
    color_d = '0;
    for (int ch = 0; ch < NumChan; ch++) begin
      acc[ch]     = AccW'(prod[0][ch]) + AccW'(prod[1][ch]) + AccW'(prod[2][ch]);
      acc_int[ch] = acc[ch][AccW-1:FracBits];
      color_d[ch*ByteW +: ByteW] = (acc_int[ch] > (AccW-FracBits)'(255)) ?
                                   {ByteW{1'b1}} : acc_int[ch][ByteW-1:0];
    end
    color_d[PixW-1 -: ByteW] = b_alpha_q;
  end

  assign res_o.valid        = c_valid_q;
  assign res_o.write_enable = c_we_q;
  assign res_o.dst_x        = c_x_q;
  assign res_o.color        = c_color_q;
  assign res_o.end_of_line  = c_eol_q;

  logic [WeightW+1:0] w_sum;
  assign w_sum = {2'b00, w_q[0]} + {2'b00, w_q[1]} + {2'b00, w_q[2]};

  a_mid_weight_sum: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (w_q[1] != '0) |-> (w_sum == (WeightW+2)'(One)))
    else $error("nonzero mid weight but weights do not sum to one");

  a_pos_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !pix_i.line_start && dest_pos_q != PosW'(PosMax))
    |=> (dest_pos_q == $past(dest_pos_q) + PosW'(1)))
    else $error("destination x did not advance by one");

  a_write_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && res_o.write_enable) |-> (DstWidthW'(res_o.dst_x) < limit))
    else $error("write flagged beyond destination width");

  a_no_write_zero_x: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_o.valid && !res_o.write_enable) |-> (res_o.dst_x == '0))
    else $error("suppressed write carries nonzero x");

endmodule

// ===== verif/antialiased_scanline_shear_top_tb.sv =====
// Testbench for the scanline shear block: directed and random lines checked against a predictor.
`timescale 1ns / 1ps
module antialiased_scanline_shear_top_tb;
  import aash_pkg::*;

  typedef struct packed {
    logic              line_start;
    logic [PosInW-1:0] top_pos;
    logic [PosInW-1:0] bottom_pos;
    pix_t              pixel;
    logic              pixel_inside;
    logic              line_end;
  } pix_beat_t;

  typedef struct packed {
    logic          write_enable;
    logic [XW-1:0] dst_x;
    pix_t          color;
    logic          end_of_line;
  } write_beat_t;

  // Tracks the sheared line: window, weights, destination x and the writes still owed.
  class shear_line_model;
    pix_t                 border;
    logic [DstWidthW-1:0] width;
    pix_t                 win [NumTaps];
    int                   dest;
    int                   w_old, w_mid, w_new;
    write_beat_t          pending_writes[$];
    int                   errors;

    function new();
      border = BorderReset;
      width  = DstWidthReset;
      foreach (win[i]) win[i] = BorderReset;
      dest   = 0;
      w_old  = 0;
      w_mid  = One;
      w_new  = 0;
      errors = 0;
    endfunction

    function void set_reg(reg_idx_e idx, logic [CfgW-1:0] data);
      case (idx)
        RegBorderColor: border = data;
        RegDstWidth:    width  = data[DstWidthW-1:0];
        default: ;
      endcase
    endfunction

    function int sat_one(int v);
      if (v < 0) return 0;
      return (v > One) ? One : v;
    endfunction

    function void latch_line(int t, int b);
      int ft, fb, tc, bc;
      ft = t >>> FracBits;
      fb = b >>> FracBits;
      tc = (ft + 1) * One;
      bc = (fb + 1) * One;
      if (ft == fb) begin
        w_new = sat_one((2 * tc - t - b) / 2);
        w_old = 0;
        w_mid = One - w_new;
      end else begin
        if (b < t) begin
          w_new = (bc - b) / 2;
          w_old = (t - bc) / 2;
        end else begin
          w_new = (tc - t) / 2;
          w_old = (b - tc) / 2;
        end
        w_new = sat_one(w_new);
        w_old = sat_one(w_old);
        // steep shear: the outer taps can eat the whole middle weight
        w_mid = One - w_old - w_new;
        if (w_mid < 0) w_mid = 0;
      end
      dest = (ft < fb) ? ft : fb;
      foreach (win[i]) win[i] = border;
    endfunction

    function void take_pixel(pix_beat_t p);
      write_beat_t w;
      int acc;
      int limit;
      if (p.line_start)
        latch_line(int'($signed(p.top_pos)), int'($signed(p.bottom_pos)));
      win[0] = win[1];
      win[1] = win[2];
      win[2] = p.pixel_inside ? p.pixel : border;
      w.color = '0;
      for (int ch = 0; ch < NumChan; ch++) begin
        acc = int'(win[0][ch*ByteW +: ByteW]) * w_old
            + int'(win[1][ch*ByteW +: ByteW]) * w_mid
            + int'(win[2][ch*ByteW +: ByteW]) * w_new;
        acc = acc >>> FracBits;
        if (acc > 255) acc = 255;
        w.color[ch*ByteW +: ByteW] = acc[ByteW-1:0];
      end
      w.color[PixW-1 -: ByteW] = win[0][PixW-1 -: ByteW];
      limit = (width < MaxWidth) ? int'(width) : MaxWidth;
      w.write_enable = (dest >= 0) && (dest < limit);
      w.dst_x        = w.write_enable ? dest[XW-1:0] : '0;
      w.end_of_line  = p.line_end;
      pending_writes.push_back(w);
      if (dest < PosMax) dest++;
    endfunction

    function void flag(string what, write_beat_t want, write_beat_t got);
      errors++;
      if (errors <= 10)
        $display("%0t: %s: exp we=%b x=%0d color=%h eol=%b, got we=%b x=%0d color=%h eol=%b",
                 $time, what, want.write_enable, want.dst_x, want.color, want.end_of_line,
                 got.write_enable, got.dst_x, got.color, got.end_of_line);
    endfunction

    function void match_write(write_beat_t got);
      write_beat_t want;
      if (pending_writes.size() == 0) begin
        flag("unexpected beat", '0, got);
      end else begin
        want = pending_writes.pop_front();
        if (got.write_enable !== want.write_enable || got.dst_x !== want.dst_x ||
            got.color !== want.color || got.end_of_line !== want.end_of_line)
          flag("beat mismatch", want, got);
      end
    endfunction
  endclass

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we;
  logic [CfgIdxW-1:0]  cfg_idx;
  logic [CfgW-1:0]     cfg_data;
  bit                  tx_idle;
  bit                  rx_idle;
  shear_line_model     shear;

  aash_in_if  pix_if ();
  aash_out_if res_if ();

  antialiased_scanline_shear_top DUT (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data),
    .pix_i      (pix_if.sink),
    .res_o      (res_if.source)
  );

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  task automatic send_pixel(input logic ls, input logic [PosInW-1:0] t, b,
                            input pix_t px, input logic in_src, le);
    int gap;
    pix_beat_t beat;
    gap = tx_idle ? $urandom_range(0, 5) : 0;
    beat.line_start   = ls;
    beat.top_pos      = t;
    beat.bottom_pos   = b;
    beat.pixel        = px;
    beat.pixel_inside = in_src;
    beat.line_end     = le;
    @(negedge clk_i);
    if (gap > 0) begin
      pix_if.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    pix_if.valid        = 1'b1;
    pix_if.line_start   = ls;
    pix_if.top_pos      = t;
    pix_if.bottom_pos   = b;
    pix_if.pixel        = px;
    pix_if.pixel_inside = in_src;
    pix_if.line_end     = le;
    do @(posedge clk_i); while (!pix_if.ready);
    shear.take_pixel(beat);
  endtask

  task automatic drain();
    @(negedge clk_i);
    pix_if.valid = 1'b0;
    while (shear.pending_writes.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic write_reg(input reg_idx_e idx, input logic [CfgW-1:0] data);
    @(negedge clk_i);
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = data;
    shear.set_reg(idx, data);
    @(negedge clk_i);
    cfg_we = 1'b0;
  endtask

  // Mostly well-formed lines with random positions; one draw in ten sends a single noise beat.
  task automatic random_lines(input int n_items);
    int sent, len, ti, bi;
    logic keep_end;
    logic [PosInW-1:0] t, b;
    sent = 0;
    while (sent < n_items) begin
      tx_idle = $urandom_range(0, 3) != 0;
      rx_idle = $urandom_range(0, 3) != 0;
      if ($urandom_range(0, 9) == 0) begin
        send_pixel(1'($urandom_range(0, 1)), PosInW'($urandom), PosInW'($urandom), $urandom,
                   1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        sent++;
      end else begin
        case ($urandom_range(0, 3))
          0:       ti = $urandom;
          1:       ti = int'($urandom_range(0, 4200 * 256)) - 100 * 256;
          default: ti = int'($urandom_range(0, 48 * 256)) - 8 * 256;
        endcase
        t = ti[PosInW-1:0];
        case ($urandom_range(0, 3))
          0: b = {t[PosInW-1:FracBits], 8'($urandom)};
          1: b = PosInW'($urandom);
          default: begin
            bi = int'($signed(t)) + int'($urandom_range(0, 1024)) - 512;
            b  = bi[PosInW-1:0];
          end
        endcase
        len      = $urandom_range(1, 40);
        keep_end = $urandom_range(0, 9) != 0;
        for (int i = 0; i < len; i++)
          send_pixel(i == 0, (i == 0) ? t : PosInW'($urandom),
                     (i == 0) ? b : PosInW'($urandom), $urandom,
                     $urandom_range(0, 4) != 0, (i == len - 1) && keep_end);
        sent += len;
      end
    end
  endtask

  // Receiver: inserts a random stall, possibly none, before each beat when idling is on.
  initial begin : rx_side
    int stall;
    res_if.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_idle ? $urandom_range(0, 5) : 0;
      @(negedge clk_i);
      if (stall > 0) begin
        res_if.ready = 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      res_if.ready = 1'b1;
      do @(posedge clk_i); while (!res_if.valid);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && res_if.valid && res_if.ready)
      shear.match_write({res_if.write_enable, res_if.dst_x, res_if.color,
                         res_if.end_of_line});
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    shear               = new();
    rst_ni              = 1'b0;
    cfg_we              = 1'b0;
    cfg_idx             = RegBorderColor;
    cfg_data            = '0;
    pix_if.valid        = 1'b0;
    pix_if.line_start   = 1'b0;
    pix_if.top_pos      = '0;
    pix_if.bottom_pos   = '0;
    pix_if.pixel        = '0;
    pix_if.pixel_inside = 1'b0;
    pix_if.line_end     = 1'b0;
    tx_idle             = 1'b1;
    rx_idle             = 1'b1;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;

    // beats before any line start run on reset weights and x
    send_pixel(0, 0, 0, 32'h1234_5678, 1, 0);
    send_pixel(0, 0, 0, 32'h80FF_7F01, 1, 0);
    send_pixel(0, 0, 0, 32'h0000_0000, 0, 0);
    // flat line on a whole pixel, border beat at the end
    send_pixel(1, 0, 0, 32'hFFFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 32'h0000_0000, 1, 0);
    send_pixel(0, 0, 0, 32'hA5A5_A5A5, 0, 1);
    // x keeps counting past line end
    send_pixel(0, 0, 0, 32'h5A5A_5A5A, 1, 0);
    send_pixel(0, 0, 0, 32'hFFFF_FFFF, 1, 1);
    // shallow shear, bottom left of top
    send_pixel(1, 21'd384, 21'd200, 32'hFFFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 32'hFFFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 32'h7F80_01FE, 1, 1);
    // steep shear, middle weight clamped to zero
    send_pixel(1, 21'd100, 21'd5000, 32'hFFFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 32'hFFFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 32'hFFFF_FFFF, 1, 1);
    // position extremes both ways
    send_pixel(1, 21'h10_0000, 21'h0F_FFFF, 32'hDEAD_BEEF, 1, 0);
    send_pixel(0, 0, 0, 32'h0123_4567, 1, 1);
    send_pixel(1, 21'h0F_FFFF, 21'h10_0000, 32'hFEDC_BA98, 1, 0);
    send_pixel(0, 0, 0, 32'h89AB_CDEF, 0, 1);
    // negative start inside one pixel: first writes suppressed
    send_pixel(1, PosInW'(-300), PosInW'(-290), 32'hFF80_4020, 1, 0);
    send_pixel(0, 0, 0, 32'h1020_4080, 1, 0);
    send_pixel(0, 0, 0, 32'hFFFF_FFFF, 1, 0);
    send_pixel(0, 0, 0, 32'h0000_0000, 1, 1);
    drain();

    write_reg(RegBorderColor, 32'h0000_0000);
    write_reg(RegDstWidth, CfgW'(1));
    random_lines(90);
    drain();

    write_reg(RegBorderColor, 32'hFFFF_FFFF);
    write_reg(RegDstWidth, CfgW'(0));
    random_lines(70);
    drain();

    // widest width register value; line starting at the far right edge
    write_reg(RegBorderColor, $urandom);
    write_reg(RegDstWidth, CfgW'(8191));
    tx_idle = 1'b0;
    rx_idle = 1'b0;
    send_pixel(1, 21'h0F_FFFF, 21'h0F_FFFF, $urandom, 1, 0);
    for (int i = 0; i < 40; i++)
      send_pixel(0, PosInW'($urandom), PosInW'($urandom), $urandom,
                 1'($urandom_range(0, 1)), i == 39);
    random_lines(80);
    drain();

    write_reg(RegBorderColor, $urandom);
    write_reg(RegDstWidth, CfgW'($urandom_range(1, MaxWidth)));
    random_lines(110);
    drain();

    write_reg(RegBorderColor, $urandom);
    write_reg(RegDstWidth, CfgW'(MaxWidth));
    random_lines(130);
    drain();
    repeat (8) @(posedge clk_i);

    if (shear.errors == 0 && shear.pending_writes.size() == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
